// ----- design/hio_pkg.sv -----
// shared types, codes and register map constants of the handheld i/o register block
package hio_pkg;

  // access codes carried by the action field
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RAISE = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // register kinds after offset decode
  typedef enum logic [3:0] {
    K_NONE,
    K_DISPCNT,
    K_STAT,
    K_LINE,
    K_BGCNT,
    K_HSCROLL,
    K_VSCROLL,
    K_KEYS,
    K_IE,
    K_IF,
    K_IME,
    K_HALT
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       hi;
    logic [1:0] bg;
  } dec_t;

  typedef struct packed {
    logic [7:0]  rd_byte;
    logic        halt;
    logic        stop;
    logic        we;
    logic [15:0] wdata;
  } upd_t;

  localparam int OFF_W      = 10;
  localparam int KEY_W      = 10;
  localparam int IRQ_W      = 14;
  localparam int MAX_BG     = 4;

  // byte offsets above the i/o base
  localparam logic [OFF_W-1:0] OFF_DISPCNT_LO = 10'h000;
  localparam logic [OFF_W-1:0] OFF_DISPCNT_HI = 10'h001;
  localparam logic [OFF_W-1:0] OFF_STAT_LO    = 10'h004;
  localparam logic [OFF_W-1:0] OFF_STAT_HI    = 10'h005;
  localparam logic [OFF_W-1:0] OFF_LINE       = 10'h006;
  localparam logic [OFF_W-1:0] OFF_BGCNT_LO   = 10'h008;
  localparam logic [OFF_W-1:0] OFF_BGCNT_HI   = 10'h00F;
  localparam logic [OFF_W-1:0] OFF_SCROLL_LO  = 10'h010;
  localparam logic [OFF_W-1:0] OFF_SCROLL_HI  = 10'h01F;
  localparam logic [OFF_W-1:0] OFF_KEYS_LO    = 10'h130;
  localparam logic [OFF_W-1:0] OFF_KEYS_HI    = 10'h131;
  localparam logic [OFF_W-1:0] OFF_IE_LO      = 10'h200;
  localparam logic [OFF_W-1:0] OFF_IE_HI      = 10'h201;
  localparam logic [OFF_W-1:0] OFF_IF_LO      = 10'h202;
  localparam logic [OFF_W-1:0] OFF_IF_HI      = 10'h203;
  localparam logic [OFF_W-1:0] OFF_IME        = 10'h208;
  localparam logic [OFF_W-1:0] OFF_HALTCNT    = 10'h301;

  localparam logic [7:0]  STAT_LOW_MASK = 8'b1011_1000;
  localparam logic [7:0]  IE_HIGH_MASK  = 8'b0011_1111;
  localparam logic [15:0] HIGH_BYTE     = 16'hFF00;
  localparam logic [15:0] IRQ_MASK      = 16'h3FFF;

  // fixed word slots in the register store, backgrounds follow
  localparam int SLOT_DISPCNT = 0;
  localparam int SLOT_STAT    = 1;
  localparam int SLOT_IE      = 2;
  localparam int SLOT_IF      = 3;
  localparam int SLOT_IME     = 4;
  localparam int SLOT_FIXED   = 5;

  function automatic logic [15:0] put_low(input logic [15:0] r, input logic [7:0] b);
    put_low = (r & HIGH_BYTE) | {8'h00, b};
  endfunction

  function automatic logic [15:0] put_high(input logic [15:0] r, input logic [7:0] b);
    put_high = (r & ~HIGH_BYTE) | {b, 8'h00};
  endfunction

endpackage

// ----- design/hio_decode.sv -----
// offset decode into register kind, byte half, background and store slot
module hio_decode #(
  parameter int NUM_BACKGROUNDS = 4,
  parameter int AW              = 5
) (
  input  logic [hio_pkg::OFF_W-1:0] offset_i,
  input  logic [1:0]                action_i,
  output hio_pkg::dec_t             dec_o,
  output logic [AW-1:0]             addr_o
);
  import hio_pkg::*;

  localparam int HS_BASE = SLOT_FIXED + NUM_BACKGROUNDS;
  localparam int VS_BASE = SLOT_FIXED + 2 * NUM_BACKGROUNDS;

  logic [1:0] bg_cnt;
  logic [1:0] bg_scr;
  logic       cnt_ok;
  logic       scr_ok;

  assign bg_cnt = offset_i[2:1];
  assign bg_scr = offset_i[3:2];
  assign cnt_ok = {1'b0, bg_cnt} < 3'(NUM_BACKGROUNDS);
  assign scr_ok = {1'b0, bg_scr} < 3'(NUM_BACKGROUNDS);

  always_comb begin
    dec_o.kind = K_NONE;
    dec_o.hi   = offset_i[0];
    dec_o.bg   = 2'd0;
    priority if (offset_i == OFF_DISPCNT_LO || offset_i == OFF_DISPCNT_HI) begin
      dec_o.kind = K_DISPCNT;
    end else if (offset_i == OFF_STAT_LO || offset_i == OFF_STAT_HI) begin
      dec_o.kind = K_STAT;
    end else if (offset_i == OFF_LINE) begin
      dec_o.kind = K_LINE;
    end else if (offset_i >= OFF_BGCNT_LO && offset_i <= OFF_BGCNT_HI) begin
      dec_o.bg   = bg_cnt;
      dec_o.kind = cnt_ok ? K_BGCNT : K_NONE;
    end else if (offset_i >= OFF_SCROLL_LO && offset_i <= OFF_SCROLL_HI) begin
      dec_o.bg = bg_scr;
      if (!scr_ok) begin
        dec_o.kind = K_NONE;
      end else if (offset_i[1]) begin
        dec_o.kind = K_VSCROLL;
      end else begin
        dec_o.kind = K_HSCROLL;
      end
    end else if (offset_i == OFF_KEYS_LO || offset_i == OFF_KEYS_HI) begin
      dec_o.kind = K_KEYS;
    end else if (offset_i == OFF_IE_LO || offset_i == OFF_IE_HI) begin
      dec_o.kind = K_IE;
    end else if (offset_i == OFF_IF_LO || offset_i == OFF_IF_HI) begin
      dec_o.kind = K_IF;
    end else if (offset_i == OFF_IME) begin
      dec_o.kind = K_IME;
    end else if (offset_i == OFF_HALTCNT) begin
      dec_o.kind = K_HALT;
    end else begin
      dec_o.kind = K_NONE;
    end
  end

  // a raise always works on the flag word, whatever the offset
  always_comb begin
    addr_o = AW'(SLOT_DISPCNT);
    if (action_e'(action_i) == ACT_RAISE) begin
      addr_o = AW'(SLOT_IF);
    end else begin
      unique case (dec_o.kind)
        K_STAT:    addr_o = AW'(SLOT_STAT);
        K_IE:      addr_o = AW'(SLOT_IE);
        K_IF:      addr_o = AW'(SLOT_IF);
        K_IME:     addr_o = AW'(SLOT_IME);
        K_BGCNT:   addr_o = AW'(SLOT_FIXED) + AW'(dec_o.bg);
        K_HSCROLL: addr_o = AW'(HS_BASE) + AW'(dec_o.bg);
        K_VSCROLL: addr_o = AW'(VS_BASE) + AW'(dec_o.bg);
        default:   addr_o = AW'(SLOT_DISPCNT);
      endcase
    end
  end

endmodule

// ----- design/hio_regmem.sv -----
// register store: synchronous word memory with per-entry valid bits and write-first read
module hio_regmem #(
  parameter int DEPTH = 17,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [15:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i
);

  logic [15:0]      mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [15:0]      rd_data_q;
  logic             rd_ok_q;
  logic             same;

  assign same = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= same ? wr_data_i : mem_q[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= same || valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : 16'h0000;

endmodule

// ----- design/hio_update.sv -----
// read merge and masked write-back of one access
module hio_update (
  input  logic [1:0]                action_i,
  input  hio_pkg::dec_t             dec_i,
  input  logic [15:0]               old_i,
  input  logic [7:0]                byte_i,
  input  logic                      vblank_i,
  input  logic                      hblank_i,
  input  logic                      match_i,
  input  logic [7:0]                line_i,
  input  logic [hio_pkg::KEY_W-1:0] keys_i,
  input  logic [hio_pkg::IRQ_W-1:0] raise_i,
  output hio_pkg::upd_t             upd_o
);
  import hio_pkg::*;

  logic [15:0] word;
  logic [15:0] keys16;

  assign keys16 = {{(16 - KEY_W){1'b0}}, keys_i};

  // read path
  always_comb begin
    word = 16'h0000;
    unique case (dec_i.kind)
      K_DISPCNT, K_BGCNT, K_HSCROLL, K_VSCROLL, K_IE, K_IF: word = old_i;
      K_KEYS:  word = keys16;
      K_STAT:  word = old_i | {13'h0000, match_i, hblank_i, vblank_i};
      K_LINE:  word = {8'h00, line_i};
      K_IME:   word = {15'h0000, old_i[0]};
      default: word = 16'h0000;
    endcase
  end

  always_comb begin
    upd_o.rd_byte = 8'h00;
    upd_o.halt    = 1'b0;
    upd_o.stop    = 1'b0;
    upd_o.we      = 1'b0;
    upd_o.wdata   = old_i;
    unique case (action_e'(action_i))
      ACT_READ: begin
        upd_o.rd_byte = dec_i.hi ? word[15:8] : word[7:0];
      end
      ACT_WRITE: begin
        unique case (dec_i.kind)
          K_DISPCNT, K_BGCNT: begin
            upd_o.we    = 1'b1;
            upd_o.wdata = dec_i.hi ? put_high(old_i, byte_i) : put_low(old_i, byte_i);
          end
          K_STAT: begin
            upd_o.we    = 1'b1;
            upd_o.wdata = dec_i.hi ? put_high(old_i, byte_i)
                                   : put_low(old_i, byte_i & STAT_LOW_MASK);
          end
          K_HSCROLL, K_VSCROLL: begin
            // high byte keeps only scroll bit 8
            upd_o.we    = 1'b1;
            upd_o.wdata = dec_i.hi ? {7'h00, byte_i[0], old_i[7:0]}
                                   : {old_i[15:8], byte_i};
          end
          K_IE: begin
            upd_o.we    = 1'b1;
            upd_o.wdata = dec_i.hi ? put_high(old_i, byte_i & IE_HIGH_MASK)
                                   : put_low(old_i, byte_i);
          end
          K_IF: begin
            // write one to clear
            upd_o.we    = 1'b1;
            upd_o.wdata = old_i & ~(dec_i.hi ? {byte_i, 8'h00} : {8'h00, byte_i}) & IRQ_MASK;
          end
          K_IME: begin
            upd_o.we    = 1'b1;
            upd_o.wdata = {15'h0000, byte_i[0]};
          end
          K_HALT: begin
            upd_o.halt = 1'b1;
            upd_o.stop = byte_i[7];
          end
          default: begin
            upd_o.we = 1'b0;
          end
        endcase
      end
      ACT_RAISE: begin
        upd_o.we    = 1'b1;
        upd_o.wdata = (old_i | {{(16 - IRQ_W){1'b0}}, raise_i}) & IRQ_MASK;
      end
      default: begin
        upd_o.we = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/handheld_io_register_block.sv -----
// top level of the handheld i/o register block: access stage, register store and result register
// a word accepted into the access stage moves into the result register when the stage commits
// throughput: one word per cycle unless the output stalls; the store is read at acceptance and
//   written back at commit, with write-first forwarding when back-to-back words hit the same slot
// the input stalls only while the access stage holds a word that the result register cannot take
// reset: asynchronous, active low; clears the handshake state and the store's valid bits, so
//   every stored word reads as zero until written

module handheld_io_register_block #(
  parameter int NUM_BACKGROUNDS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // access words
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [hio_pkg::OFF_W-1:0] offset_i,
  input  logic [7:0]                write_byte_i,
  input  logic                      in_vblank_i,
  input  logic                      in_hblank_i,
  input  logic                      line_match_i,
  input  logic [7:0]                line_count_i,
  input  logic [hio_pkg::KEY_W-1:0] key_state_i,
  input  logic [hio_pkg::IRQ_W-1:0] raise_mask_i,
  // result words
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                read_byte_o,
  output logic                      halt_request_o,
  output logic                      stop_request_o
);
  import hio_pkg::*;

  // store layout: five fixed slots, then control, horizontal and vertical scroll per background
  localparam int DEPTH = SLOT_FIXED + 3 * NUM_BACKGROUNDS;
  localparam int AW    = $clog2(DEPTH);

  // handshake
  logic in_accept;
  logic commit;
  logic out_take;

  // decode of the incoming word
  dec_t          dec;
  logic [AW-1:0] addr;

  // access stage
  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_act_q;
  dec_t              s1_dec_q;
  logic [AW-1:0]     s1_addr_q;
  logic [7:0]        s1_byte_q;
  logic              s1_vb_q, s1_hb_q, s1_lm_q;
  logic [7:0]        s1_line_q;
  logic [KEY_W-1:0]  s1_keys_q;
  logic [IRQ_W-1:0]  s1_raise_q;

  // store and update
  logic [15:0] old_word;
  upd_t        upd;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] rd_byte_q;
  logic       halt_q;
  logic       stop_q;

  // stage moves on when the result register is empty or being emptied
  assign out_take   = out_valid_q && !out_stall_i;
  assign commit     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !commit;
  assign in_accept  = in_valid_i && !in_stall_o;

  hio_decode #(
    .NUM_BACKGROUNDS (NUM_BACKGROUNDS),
    .AW              (AW)
  ) u_decode (
    .offset_i (offset_i),
    .action_i (action_i),
    .dec_o    (dec),
    .addr_o   (addr)
  );

  // read issued at acceptance, write-back when the stage commits
  hio_regmem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_regmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (addr),
    .rd_data_o (old_word),
    .wr_en_i   (commit && upd.we),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (upd.wdata)
  );

  hio_update u_update (
    .action_i (s1_act_q),
    .dec_i    (s1_dec_q),
    .old_i    (old_word),
    .byte_i   (s1_byte_q),
    .vblank_i (s1_vb_q),
    .hblank_i (s1_hb_q),
    .match_i  (s1_lm_q),
    .line_i   (s1_line_q),
    .keys_i   (s1_keys_q),
    .raise_i  (s1_raise_q),
    .upd_o    (upd)
  );

  // control next state
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // access stage payload, live status inputs sampled with the word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_act_q   <= action_i;
      s1_dec_q   <= dec;
      s1_addr_q  <= addr;
      s1_byte_q  <= write_byte_i;
      s1_vb_q    <= in_vblank_i;
      s1_hb_q    <= in_hblank_i;
      s1_lm_q    <= line_match_i;
      s1_line_q  <= line_count_i;
      s1_keys_q  <= key_state_i;
      s1_raise_q <= raise_mask_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      rd_byte_q <= upd.rd_byte;
      halt_q    <= upd.halt;
      stop_q    <= upd.stop;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_byte_o    = rd_byte_q;
  assign halt_request_o = halt_q;
  assign stop_request_o = stop_q;

  // an accepted word always occupies the access stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted word lost before the access stage");

  // a held word with an empty result register must move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |-> !in_stall_o)
    else $error("access stage stalled with empty result register");

  // a committed word shows up in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed word not presented");

  // stop is only ever a flavour of a halt request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stop_q) |-> halt_q)
    else $error("stop request without halt request");

  // halt requests come from writes, which return no read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && halt_q) |-> (rd_byte_q == 8'h00))
    else $error("halt request carries read data");

endmodule

// ----- sim/tb_handheld_io_register_block.sv -----
// self-checking testbench for the handheld i/o register block: directed and random bus words
module tb_handheld_io_register_block;
  import hio_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int BG_COUNT    = 4;
  localparam int WORDS_PHASE = 340;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_TAIL  = 4;
  localparam int CYCLE_LIMIT = 200000;

  // one access word as the sender offers it
  typedef struct packed {
    action_e     act;
    logic [9:0]  off;
    logic [7:0]  wbyte;
    logic        vb;
    logic        hb;
    logic        lm;
    logic [7:0]  line;
    logic [9:0]  keys;
    logic [13:0] raise;
  } access_t;

  // one result word
  typedef struct packed {
    logic [7:0] rd;
    logic       halt;
    logic       stop;
  } result_t;

  // register map predictor with a queue of the results it expects
  class io_map_scoreboard;
    logic [15:0] disp_ctrl;
    logic [15:0] disp_stat;
    logic [15:0] bg_ctrl [MAX_BG];
    logic [8:0]  hscroll [MAX_BG];
    logic [8:0]  vscroll [MAX_BG];
    logic [13:0] irq_en;
    logic [13:0] irq_flags;
    logic        ime;
    result_t     awaited_results [$];
    int          mismatches;

    function new();
      disp_ctrl = '0;
      disp_stat = '0;
      irq_en    = '0;
      irq_flags = '0;
      ime       = 1'b0;
      for (int i = 0; i < MAX_BG; i++) begin
        bg_ctrl[i] = '0;
        hscroll[i] = '0;
        vscroll[i] = '0;
      end
      mismatches = 0;
    endfunction

    function logic [7:0] read_register(access_t a);
      logic [15:0] word;
      int unsigned n;
      word = '0;
      if (a.off <= OFF_DISPCNT_HI) word = disp_ctrl;
      else if (a.off == OFF_STAT_LO) return disp_stat[7:0] | {5'b0, a.lm, a.hb, a.vb};
      else if (a.off == OFF_STAT_HI) return disp_stat[15:8];
      else if (a.off == OFF_LINE) return a.line;
      else if (a.off >= OFF_BGCNT_LO && a.off <= OFF_BGCNT_HI) begin
        n = (a.off - OFF_BGCNT_LO) >> 1;
        if (n >= BG_COUNT) return 8'h00;
        word = bg_ctrl[n];
      end else if (a.off >= OFF_SCROLL_LO && a.off <= OFF_SCROLL_HI) begin
        n = (a.off - OFF_SCROLL_LO) >> 2;
        if (n >= BG_COUNT) return 8'h00;
        word = a.off[1] ? {7'b0, vscroll[n]} : {7'b0, hscroll[n]};
      end else if (a.off == OFF_KEYS_LO || a.off == OFF_KEYS_HI) word = {6'b0, a.keys};
      else if (a.off == OFF_IE_LO || a.off == OFF_IE_HI) word = {2'b0, irq_en};
      else if (a.off == OFF_IF_LO || a.off == OFF_IF_HI) word = {2'b0, irq_flags};
      else if (a.off == OFF_IME) return {7'b0, ime};
      else return 8'h00;
      return a.off[0] ? word[15:8] : word[7:0];
    endfunction

    function void write_register(access_t a);
      int unsigned n;
      logic [7:0] masked;
      if (a.off == OFF_DISPCNT_LO) disp_ctrl[7:0] = a.wbyte;
      else if (a.off == OFF_DISPCNT_HI) disp_ctrl[15:8] = a.wbyte;
      else if (a.off == OFF_STAT_LO) disp_stat[7:0] = a.wbyte & STAT_LOW_MASK;
      else if (a.off == OFF_STAT_HI) disp_stat[15:8] = a.wbyte;
      else if (a.off >= OFF_BGCNT_LO && a.off <= OFF_BGCNT_HI) begin
        n = (a.off - OFF_BGCNT_LO) >> 1;
        if (n < BG_COUNT) begin
          if (a.off[0]) bg_ctrl[n][15:8] = a.wbyte;
          else bg_ctrl[n][7:0] = a.wbyte;
        end
      end else if (a.off >= OFF_SCROLL_LO && a.off <= OFF_SCROLL_HI) begin
        n = (a.off - OFF_SCROLL_LO) >> 2;
        if (n < BG_COUNT) begin
          // high byte keeps only scroll bit 8
          case ({a.off[1], a.off[0]})
            2'b00: hscroll[n][7:0] = a.wbyte;
            2'b01: hscroll[n][8]   = a.wbyte[0];
            2'b10: vscroll[n][7:0] = a.wbyte;
            default: vscroll[n][8] = a.wbyte[0];
          endcase
        end
      end else if (a.off == OFF_IE_LO) irq_en[7:0] = a.wbyte;
      else if (a.off == OFF_IE_HI) begin
        masked = a.wbyte & IE_HIGH_MASK;
        irq_en[13:8] = masked[5:0];
      end else if (a.off == OFF_IF_LO) irq_flags[7:0] = irq_flags[7:0] & ~a.wbyte;
      else if (a.off == OFF_IF_HI) irq_flags[13:8] = irq_flags[13:8] & ~a.wbyte[5:0];
      else if (a.off == OFF_IME) ime = a.wbyte[0];
    endfunction

    // note an accepted access word and queue the result it must give
    function void note_access(access_t a);
      result_t want;
      want = '0;
      case (a.act)
        ACT_READ: want.rd = read_register(a);
        ACT_WRITE: begin
          if (a.off == OFF_HALTCNT) begin
            want.halt = 1'b1;
            want.stop = a.wbyte[7];
          end else begin
            write_register(a);
          end
        end
        ACT_RAISE: irq_flags = irq_flags | a.raise;
        default: ;
      endcase
      awaited_results.push_back(want);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(logic [7:0] rd, logic halt, logic stop);
      result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word: read_byte %02h halt %b stop %b",
                 $time, rd, halt, stop);
        return;
      end
      want = awaited_results.pop_front();
      if (rd !== want.rd) begin
        mismatches++;
        $display("%0t: read_byte expected %02h actual %02h", $time, want.rd, rd);
      end
      if (halt !== want.halt) begin
        mismatches++;
        $display("%0t: halt_request expected %b actual %b", $time, want.halt, halt);
      end
      if (stop !== want.stop) begin
        mismatches++;
        $display("%0t: stop_request expected %b actual %b", $time, want.stop, stop);
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  // clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_NONE;
  logic [9:0]  offset = '0;
  logic [7:0]  write_byte = '0;
  logic        in_vblank = 1'b0;
  logic        in_hblank = 1'b0;
  logic        line_match = 1'b0;
  logic [7:0]  line_count = '0;
  logic [9:0]  key_state = '0;
  logic [13:0] raise_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_byte;
  logic        halt_request;
  logic        stop_request;

  // traffic shaping, percentages out of a hundred
  int idle_pct = 0;
  int stall_pct = 0;
  // a bump of hold_ticket asks the receiver for one long hold-off
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  io_map_scoreboard sb;

  handheld_io_register_block #(
    .NUM_BACKGROUNDS(BG_COUNT)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .offset_i       (offset),
    .write_byte_i   (write_byte),
    .in_vblank_i    (in_vblank),
    .in_hblank_i    (in_hblank),
    .line_match_i   (line_match),
    .line_count_i   (line_count),
    .key_state_i    (key_state),
    .raise_mask_i   (raise_mask),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_byte_o    (read_byte),
    .halt_request_o (halt_request),
    .stop_request_o (stop_request)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked so the block backs up
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result words are sampled mid-cycle, where ports have settled, and taken at the next edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(read_byte, halt_request, stop_request);
  end

  // access word with the given operation; live inputs and the raise mask are random
  function automatic access_t make_access(action_e act, logic [9:0] off, logic [7:0] b);
    access_t a;
    a.act   = act;
    a.off   = off;
    a.wbyte = b;
    a.vb    = 1'($urandom_range(1));
    a.hb    = 1'($urandom_range(1));
    a.lm    = 1'($urandom_range(1));
    a.line  = 8'($urandom_range(255));
    a.keys  = 10'($urandom_range(1023));
    a.raise = 14'($urandom_range(16383));
    return a;
  endfunction

  // offsets weighted towards the mapped registers, with some anywhere in the window
  function automatic logic [9:0] pick_offset();
    case ($urandom_range(9))
      0, 9: return 10'($urandom_range(1023));
      1: return OFF_DISPCNT_LO + 10'($urandom_range(7));
      2, 3: return OFF_BGCNT_LO + 10'($urandom_range(23));
      4: return OFF_KEYS_LO + 10'($urandom_range(1));
      5, 6: return OFF_IE_LO + 10'($urandom_range(11));
      7: return OFF_HALTCNT;
      default: return OFF_STAT_LO + 10'($urandom_range(2));
    endcase
  endfunction

  function automatic access_t random_access();
    int unsigned r;
    action_e act;
    r = $urandom_range(99);
    if (r < 40) act = ACT_READ;
    else if (r < 80) act = ACT_WRITE;
    else if (r < 92) act = ACT_RAISE;
    else act = ACT_NONE;
    return make_access(act, pick_offset(), 8'($urandom_range(255)));
  endfunction

  // offer one word, with random idle cycles first, and hold it until taken
  task automatic drive_access(input access_t a);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= a.act;
    offset     <= a.off;
    write_byte <= a.wbyte;
    in_vblank  <= a.vb;
    in_hblank  <= a.hb;
    line_match <= a.lm;
    line_count <= a.line;
    key_state  <= a.keys;
    raise_mask <= a.raise;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_access(a);
  endtask

  // sender goes quiet until every expected word is back, then a short tail
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input bit with_hold);
    idle_pct  <= idle;
    stall_pct <= stall;
    for (int i = 0; i < WORDS_PHASE; i++) begin
      if (with_hold && i == WORDS_PHASE / 3) hold_ticket <= hold_ticket + 1;
      drive_access(random_access());
    end
    wait_drain();
  endtask

  initial begin
    access_t a;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words: field extremes, masks, read-only and unmapped offsets, halt and stop
    drive_access(make_access(ACT_WRITE, OFF_DISPCNT_HI, 8'hFF));
    drive_access(make_access(ACT_READ, OFF_DISPCNT_HI, 8'h00));
    drive_access(make_access(ACT_WRITE, OFF_STAT_LO, 8'hFF));
    a = make_access(ACT_READ, OFF_STAT_LO, 8'h00);
    a.vb = 1'b1;
    a.hb = 1'b1;
    a.lm = 1'b1;
    drive_access(a);
    a = make_access(ACT_READ, OFF_LINE, 8'h00);
    a.line = 8'hFF;
    drive_access(a);
    // line counter is read only
    drive_access(make_access(ACT_WRITE, OFF_LINE, 8'h55));
    drive_access(make_access(ACT_READ, OFF_LINE + 10'd1, 8'h00));
    drive_access(make_access(ACT_WRITE, OFF_BGCNT_HI, 8'hFF));
    drive_access(make_access(ACT_READ, OFF_BGCNT_HI, 8'h00));
    // scroll high byte keeps bit 8 only
    drive_access(make_access(ACT_WRITE, OFF_SCROLL_HI, 8'hFF));
    drive_access(make_access(ACT_READ, OFF_SCROLL_HI, 8'h00));
    a = make_access(ACT_READ, OFF_KEYS_HI, 8'h00);
    a.keys = 10'h3FF;
    drive_access(a);
    drive_access(make_access(ACT_WRITE, OFF_IE_HI, 8'hFF));
    drive_access(make_access(ACT_READ, OFF_IE_HI, 8'h00));
    a = make_access(ACT_RAISE, OFF_IF_LO, 8'h00);
    a.raise = 14'h3FFF;
    drive_access(a);
    // writing ones clears flags
    drive_access(make_access(ACT_WRITE, OFF_IF_LO, 8'hFF));
    drive_access(make_access(ACT_READ, OFF_IF_HI, 8'h00));
    drive_access(make_access(ACT_READ, OFF_IF_LO, 8'h00));
    drive_access(make_access(ACT_WRITE, OFF_IME, 8'hFF));
    drive_access(make_access(ACT_READ, OFF_IME, 8'h00));
    drive_access(make_access(ACT_WRITE, OFF_HALTCNT, 8'h80));
    drive_access(make_access(ACT_WRITE, OFF_HALTCNT, 8'h7F));
    // halt control read gives nothing
    drive_access(make_access(ACT_READ, OFF_HALTCNT, 8'h00));
    drive_access(make_access(ACT_WRITE, 10'h3FF, 8'hFF));
    drive_access(make_access(ACT_READ, 10'h3FF, 8'h00));
    drive_access(make_access(ACT_NONE, OFF_STAT_LO, 8'hFF));
    wait_drain();

    // random words under each traffic pattern; the first one also backs the block up
    run_phase(0, 0, 1'b1);
    run_phase(58, 0, 1'b0);
    run_phase(0, 58, 1'b0);
    run_phase(30, 30, 1'b0);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
